FILE: sv/lstc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lstc_pkg
// Shared types and constants of the link setup/teardown controller.
// ----------------------------------------------------------------------------
package lstc_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned StatusW  = 3;
   localparam int unsigned CmdW     = 2;
   localparam int unsigned AttemptW = 4;
   localparam int unsigned TickW    = 16;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned BeatW    = 3;

   localparam logic [BeatW-1:0] BeatFlagOpen  = 3'd0;
   localparam logic [BeatW-1:0] BeatAddr      = 3'd1;
   localparam logic [BeatW-1:0] BeatCtrl      = 3'd2;
   localparam logic [BeatW-1:0] BeatBcc       = 3'd3;
   localparam logic [BeatW-1:0] BeatFlagClose = 3'd4;

   localparam logic [CmdW-1:0] CMD_START = 2'd0;
   localparam logic [CmdW-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CmdW-1:0] CMD_TICK  = 2'd2;

   localparam logic [StatusW-1:0] ST_IDLE     = 3'd0;
   localparam logic [StatusW-1:0] ST_BUSY     = 3'd1;
   localparam logic [StatusW-1:0] ST_DONE     = 3'd2;
   localparam logic [StatusW-1:0] ST_CONN_ERR = 3'd3;
   localparam logic [StatusW-1:0] ST_DISC_ERR = 3'd4;

   localparam logic [CsrIdxW-1:0] REG_FLAG      = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_CMD_ADDR  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_ANS_ADDR  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SET_CTRL  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_UA_CTRL   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_DISC_CTRL = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_MAX_ATT   = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_TIMEOUT   = 3'd7;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_CONN  = 6'b000010,
      PH_DISC  = 6'b000100,
      PH_DONE  = 6'b001000,
      PH_CFAIL = 6'b010000,
      PH_DFAIL = 6'b100000
   } phase_type;

   typedef enum logic [4:0] {
      M_START = 5'b00001,
      M_FLAG  = 5'b00010,
      M_ADDR  = 5'b00100,
      M_CTRL  = 5'b01000,
      M_BCC   = 5'b10000
   } match_type;

   // one queued job: a five-byte frame or a single status word
   typedef struct packed {
      logic               is_frame;
      logic [ByteW-1:0]   flag;
      logic [ByteW-1:0]   addr;
      logic [ByteW-1:0]   ctrl;
      logic [StatusW-1:0] status;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage : lstc_pkg
`default_nettype wire

FILE: sv/lstc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lstc_front
// Config registers, handshake phase, reply matcher, retry timer; turns each
// accepted item into one job for the queue.
// ----------------------------------------------------------------------------
module lstc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [lstc_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [lstc_pkg::CsrDataW-1:0]  csr_data,
   input  wire logic                           item_take,
   input  wire logic [lstc_pkg::CmdW-1:0]      item_cmd,
   input  wire logic [lstc_pkg::ByteW-1:0]     item_byte,
   output lstc_pkg::job_type                   job
);
   import lstc_pkg::*;

   logic [ByteW-1:0]    flag_ff, cmd_addr_ff, ans_addr_ff;
   logic [ByteW-1:0]    set_ctrl_ff, ua_ctrl_ff, disc_ctrl_ff;
   logic [AttemptW-1:0] max_att_ff;
   logic [TickW-1:0]    timeout_ff;

   phase_type           phase_ff, phase_in;
   match_type           match_ff, match_in, match_nx;
   logic [AttemptW-1:0] att_ff, att_in;
   logic [TickW-1:0]    tick_ff, tick_in, tick_inc;

   logic                active, hit;
   logic [ByteW-1:0]    exp_addr, exp_ctrl, exp_bcc;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= 8'h7E;
         cmd_addr_ff  <= 8'd3;
         ans_addr_ff  <= 8'd1;
         set_ctrl_ff  <= 8'd3;
         ua_ctrl_ff   <= 8'd7;
         disc_ctrl_ff <= 8'd11;
         max_att_ff   <= 4'd3;
         timeout_ff   <= 16'd3;
      end else if (csr_we) begin
         case (csr_index)
            REG_FLAG:      flag_ff      <= csr_data[ByteW-1:0];
            REG_CMD_ADDR:  cmd_addr_ff  <= csr_data[ByteW-1:0];
            REG_ANS_ADDR:  ans_addr_ff  <= csr_data[ByteW-1:0];
            REG_SET_CTRL:  set_ctrl_ff  <= csr_data[ByteW-1:0];
            REG_UA_CTRL:   ua_ctrl_ff   <= csr_data[ByteW-1:0];
            REG_DISC_CTRL: disc_ctrl_ff <= csr_data[ByteW-1:0];
            REG_MAX_ATT:   max_att_ff   <= csr_data[AttemptW-1:0];
            REG_TIMEOUT:   timeout_ff   <= csr_data[TickW-1:0];
            default:       flag_ff      <= flag_ff;
         endcase
      end
   end

   assign active   = (phase_ff == PH_CONN) || (phase_ff == PH_DISC);
   assign exp_addr = (phase_ff == PH_CONN) ? cmd_addr_ff : ans_addr_ff;
   assign exp_ctrl = (phase_ff == PH_CONN) ? ua_ctrl_ff : disc_ctrl_ff;
   assign exp_bcc  = exp_addr ^ exp_ctrl;
   assign tick_inc = tick_ff + 16'd1;

   // reply matcher: opening flag first, then address, control, BCC, closing flag
   always_comb begin
      hit      = 1'b0;
      match_nx = M_START;
      case (match_ff)
         M_START: match_nx = (item_byte == flag_ff) ? M_FLAG : M_START;
         M_FLAG: begin
            if (item_byte == exp_addr)     match_nx = M_ADDR;
            else if (item_byte == flag_ff) match_nx = M_FLAG;
            else                           match_nx = M_START;
         end
         M_ADDR: begin
            if (item_byte == exp_ctrl)     match_nx = M_CTRL;
            else if (item_byte == flag_ff) match_nx = M_FLAG;
            else                           match_nx = M_START;
         end
         M_CTRL: begin
            if (item_byte == exp_bcc)      match_nx = M_BCC;
            else if (item_byte == flag_ff) match_nx = M_FLAG;
            else                           match_nx = M_START;
         end
         M_BCC: begin
            match_nx = M_START;
            hit      = (item_byte == flag_ff);
         end
         default: match_nx = M_START;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      match_in     = match_ff;
      att_in       = att_ff;
      tick_in      = tick_ff;
      job.is_frame = 1'b0;
      job.flag     = flag_ff;
      job.addr     = cmd_addr_ff;
      job.ctrl     = set_ctrl_ff;
      case (item_cmd)
         CMD_START: begin
            phase_in     = PH_CONN;
            match_in     = M_START;
            att_in       = 4'd1;
            tick_in      = '0;
            job.is_frame = 1'b1;
         end
         CMD_BYTE: begin
            if (active) begin
               match_in = match_nx;
               if (hit) begin
                  match_in     = M_START;
                  tick_in      = '0;
                  job.is_frame = 1'b1;
                  if (phase_ff == PH_CONN) begin
                     phase_in = PH_DISC;
                     att_in   = 4'd1;
                     job.ctrl = disc_ctrl_ff;
                  end else begin
                     phase_in = PH_DONE;
                     job.addr = ans_addr_ff;
                     job.ctrl = ua_ctrl_ff;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (active) begin
               tick_in = tick_inc;
               if (tick_inc >= timeout_ff) begin
                  tick_in  = '0;
                  match_in = M_START;
                  if (att_ff >= max_att_ff) begin
                     phase_in = (phase_ff == PH_CONN) ? PH_CFAIL : PH_DFAIL;
                  end else begin
                     att_in       = att_ff + 4'd1;
                     job.is_frame = 1'b1;
                     job.ctrl     = (phase_ff == PH_CONN) ? set_ctrl_ff : disc_ctrl_ff;
                  end
               end
            end
         end
         default: phase_in = phase_ff;
      endcase
      case (phase_in)
         PH_CONN, PH_DISC: job.status = ST_BUSY;
         PH_DONE:          job.status = ST_DONE;
         PH_CFAIL:         job.status = ST_CONN_ERR;
         PH_DFAIL:         job.status = ST_DISC_ERR;
         default:          job.status = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         match_ff <= M_START;
         att_ff   <= '0;
         tick_ff  <= '0;
      end else if (item_take) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         att_ff   <= att_in;
         tick_ff  <= tick_in;
      end
   end

endmodule : lstc_front
`default_nettype wire

FILE: sv/lstc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lstc_queue
// Short job queue between the front end and the frame serializer.
// ----------------------------------------------------------------------------
module lstc_queue #(
   parameter int unsigned Depth = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lstc_pkg::qctl_type ctl,
   input  wire lstc_pkg::job_type  wr_job,
   output lstc_pkg::job_type       rd_job,
   output lstc_pkg::qstat_type     stat
);
   import lstc_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   job_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] cnt_ff;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] r;
      r = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
      return r;
   endfunction

   assign stat.full  = (cnt_ff == CntW'(Depth));
   assign stat.empty = (cnt_ff == '0);
   assign rd_job     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (ctl.push) slot_ff[wr_ptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (ctl.push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (ctl.pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (ctl.push && !ctl.pop)      cnt_ff <= cnt_ff + CntW'(1);
         else if (ctl.pop && !ctl.push) cnt_ff <= cnt_ff - CntW'(1);
      end
   end

endmodule : lstc_queue
`default_nettype wire

FILE: sv/lstc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lstc_back
// Frame serializer: expands a job into five frame words or one status word.
// ----------------------------------------------------------------------------
module lstc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lstc_pkg::job_type             q_job,
   input  wire logic                          q_empty,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [15:0]                        rsp_tdata,  // tx_byte, status
   output logic                               rsp_tuser,  // tx_valid
   output logic                               rsp_tlast
);
   import lstc_pkg::*;

   job_type          job_ff;
   logic             vld_ff;
   logic [BeatW-1:0] beat_ff;
   logic             last_beat, done;
   logic [ByteW-1:0] tx_byte;

   assign last_beat = !job_ff.is_frame || (beat_ff == BeatFlagClose);
   assign done      = !vld_ff || (rsp_tready && last_beat);
   assign q_pop     = done && !q_empty;

   always_comb begin
      tx_byte = '0;
      if (job_ff.is_frame) begin
         case (beat_ff)
            BeatFlagOpen, BeatFlagClose: tx_byte = job_ff.flag;
            BeatAddr:                    tx_byte = job_ff.addr;
            BeatCtrl:                    tx_byte = job_ff.ctrl;
            BeatBcc:                     tx_byte = job_ff.addr ^ job_ff.ctrl;
            default:                     tx_byte = '0;
         endcase
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {5'd0, job_ff.status, tx_byte};
   assign rsp_tuser  = job_ff.is_frame;
   assign rsp_tlast  = last_beat;

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         beat_ff <= '0;
      end else if (done) begin
         vld_ff  <= !q_empty;
         beat_ff <= '0;
      end else if (rsp_tready) begin
         beat_ff <= beat_ff + BeatW'(1);
      end
   end

endmodule : lstc_back
`default_nettype wire

FILE: sv/link_setup_teardown_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// link_setup_teardown_controller
// Sender side of a SET/UA, DISC/DISC, UA supervisory-frame link handshake.
// ----------------------------------------------------------------------------
// An item (req_tuser = start, received byte or tick) is taken whenever the
// job queue has room, so items may follow back to back. Each item yields
// either one status word or a five-word frame; the serializer sends one
// word per cycle while rsp_tready is high, so a frame item occupies the
// output for five words and a status item for one. Queue depth sets how
// many items can be taken ahead of a stalled output. Config writes are
// always ready and take effect on the next item.
module link_setup_teardown_controller #(
   parameter int unsigned QueueDepth = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte
   input  wire logic [1:0]   req_tuser,   // cmd
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // tx_byte [7:0], status [10:8]
   output logic              rsp_tuser,   // tx_valid
   output logic              rsp_tlast
);
   import lstc_pkg::*;

   job_type   fe_job, q_job;
   qctl_type  qctl;
   qstat_type qstat;
   logic      take;

   assign csr_ready  = 1'b1;
   assign req_tready = !qstat.full;
   assign take       = req_tvalid && req_tready;
   assign qctl.push  = take;

   lstc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item_take (take),
      .item_cmd  (req_tuser),
      .item_byte (req_tdata),
      .job       (fe_job)
   );

   lstc_queue #(.Depth(QueueDepth)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (qctl),
      .wr_job (fe_job),
      .rd_job (q_job),
      .stat   (qstat)
   );

   lstc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_job      (q_job),
      .q_empty    (qstat.empty),
      .q_pop      (qctl.pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : link_setup_teardown_controller
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the link setup/teardown controller.
// ----------------------------------------------------------------------------
// Drives start, line-byte and tick words into the request stream. It tracks
// the handshake (phase, reply matcher, attempts, ticks) alongside the block
// and queues the frame or status words that each accepted word should cause.
// Every response word is checked field by field against the oldest queued
// word. The run covers directed handshakes, retry and give-up, then random
// sessions under several register settings, including both corners, and
// with source gaps and sink back-pressure mixed in.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lstc_pkg::*;

   localparam int unsigned StallLimit  = 2000;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned FrameLen    = 5;
   localparam logic [CmdW-1:0] CmdUnused = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0]   tx_byte;
      logic               tx_valid;
      logic               last;
      logic [StatusW-1:0] status;
   } line_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_ready;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // register copies
   logic [ByteW-1:0]    cfg_flag, cfg_cmd_addr, cfg_ans_addr;
   logic [ByteW-1:0]    cfg_set_ctrl, cfg_ua_ctrl, cfg_disc_ctrl;
   logic [AttemptW-1:0] cfg_max_att;
   logic [TickW-1:0]    cfg_timeout;

   // handshake tracking
   phase_type           ph;
   match_type           rx_match;
   logic [AttemptW-1:0] attempts;
   logic [TickW-1:0]    ticks;

   line_word_type words_due[$];
   int unsigned errors         = 0;
   int unsigned items_sent     = 0;
   int unsigned src_idle_pct   = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned quiet_cycles   = 0;

   link_setup_teardown_controller dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // ------------------------------------------------------------------------
   // handshake prediction
   // ------------------------------------------------------------------------
   function automatic void reset_link_state();
      cfg_flag      = 8'h7E;
      cfg_cmd_addr  = 8'h03;
      cfg_ans_addr  = 8'h01;
      cfg_set_ctrl  = 8'h03;
      cfg_ua_ctrl   = 8'h07;
      cfg_disc_ctrl = 8'h0B;
      cfg_max_att   = 4'd3;
      cfg_timeout   = 16'd3;
      ph            = PH_IDLE;
      rx_match      = M_START;
      attempts      = '0;
      ticks         = '0;
   endfunction

   function automatic logic [StatusW-1:0] link_status();
      case (ph)
         PH_CONN, PH_DISC: return ST_BUSY;
         PH_DONE:          return ST_DONE;
         PH_CFAIL:         return ST_CONN_ERR;
         PH_DFAIL:         return ST_DISC_ERR;
         default:          return ST_IDLE;
      endcase
   endfunction

   function automatic void queue_status();
      line_word_type w;
      w.tx_byte  = '0;
      w.tx_valid = 1'b0;
      w.last     = 1'b1;
      w.status   = link_status();
      words_due.push_back(w);
   endfunction

   function automatic void queue_frame(logic [ByteW-1:0] addr, logic [ByteW-1:0] ctrl);
      logic [ByteW-1:0] bytes [FrameLen];
      line_word_type    w;
      int               k;
      bytes[0] = cfg_flag;
      bytes[1] = addr;
      bytes[2] = ctrl;
      bytes[3] = addr ^ ctrl;
      bytes[4] = cfg_flag;
      for (k = 0; k < FrameLen; k++) begin
         w.tx_byte  = bytes[k];
         w.tx_valid = 1'b1;
         w.last     = (k == FrameLen - 1);
         w.status   = link_status();
         words_due.push_back(w);
      end
   endfunction

   // true when b closes a complete reply
   function automatic logic reply_complete(logic [ByteW-1:0] b, logic [ByteW-1:0] addr,
                                           logic [ByteW-1:0] ctrl);
      logic [ByteW-1:0] bcc;
      bcc = addr ^ ctrl;
      case (rx_match)
         M_START: begin
            if (b == cfg_flag) rx_match = M_FLAG;
            return 1'b0;
         end
         M_FLAG: begin
            if (b == addr) rx_match = M_ADDR;
            else if (b != cfg_flag) rx_match = M_START;
            return 1'b0;
         end
         M_ADDR: begin
            if (b == ctrl) rx_match = M_CTRL;
            else if (b == cfg_flag) rx_match = M_FLAG;
            else rx_match = M_START;
            return 1'b0;
         end
         M_CTRL: begin
            if (b == bcc) rx_match = M_BCC;
            else if (b == cfg_flag) rx_match = M_FLAG;
            else rx_match = M_START;
            return 1'b0;
         end
         M_BCC: begin
            rx_match = M_START;
            return (b == cfg_flag);
         end
         default: begin
            rx_match = M_START;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void advance_handshake(logic [CmdW-1:0] cmd, logic [ByteW-1:0] rx);
      logic busy;
      busy = (ph == PH_CONN) || (ph == PH_DISC);
      if (cmd == CMD_START) begin
         ph       = PH_CONN;
         rx_match = M_START;
         attempts = 4'd1;
         ticks    = '0;
         queue_frame(cfg_cmd_addr, cfg_set_ctrl);
      end else if (cmd == CMD_BYTE && busy) begin
         if (ph == PH_CONN) begin
            if (reply_complete(rx, cfg_cmd_addr, cfg_ua_ctrl)) begin
               ph       = PH_DISC;
               rx_match = M_START;
               attempts = 4'd1;
               ticks    = '0;
               queue_frame(cfg_cmd_addr, cfg_disc_ctrl);
            end else begin
               queue_status();
            end
         end else if (reply_complete(rx, cfg_ans_addr, cfg_disc_ctrl)) begin
            ph       = PH_DONE;
            rx_match = M_START;
            ticks    = '0;
            queue_frame(cfg_ans_addr, cfg_ua_ctrl);
         end else begin
            queue_status();
         end
      end else if (cmd == CMD_TICK && busy) begin
         ticks = ticks + TickW'(1);
         if (ticks >= cfg_timeout) begin
            ticks    = '0;
            rx_match = M_START;
            if (attempts >= cfg_max_att) begin
               ph = (ph == PH_CONN) ? PH_CFAIL : PH_DFAIL;
               queue_status();
            end else begin
               attempts = attempts + AttemptW'(1);
               queue_frame(cfg_cmd_addr, (ph == PH_CONN) ? cfg_set_ctrl : cfg_disc_ctrl);
            end
         end else begin
            queue_status();
         end
      end else begin
         queue_status();
      end
   endfunction

   // ------------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      line_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%b tlast=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = words_due.pop_front();
            if (rsp_tdata[7:0] !== want.tx_byte) begin
               errors++;
               $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte,
                        rsp_tdata[7:0]);
            end
            if (rsp_tdata[10:8] !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tdata[10:8]);
            end
            if (rsp_tuser !== want.tx_valid) begin
               errors++;
               $display("%0t: tx_valid expected %b actual %b", $time, want.tx_valid, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_word(logic [CmdW-1:0] cmd, logic [ByteW-1:0] rx);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      advance_handshake(cmd, rx);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_FLAG:      cfg_flag      = data[7:0];
         REG_CMD_ADDR:  cfg_cmd_addr  = data[7:0];
         REG_ANS_ADDR:  cfg_ans_addr  = data[7:0];
         REG_SET_CTRL:  cfg_set_ctrl  = data[7:0];
         REG_UA_CTRL:   cfg_ua_ctrl   = data[7:0];
         REG_DISC_CTRL: cfg_disc_ctrl = data[7:0];
         REG_MAX_ATT:   cfg_max_att   = data[3:0];
         REG_TIMEOUT:   cfg_timeout   = data[15:0];
         default: ;
      endcase
   endtask

   // upper bits are don't-care in the narrow registers
   function automatic logic [CsrDataW-1:0] with_junk(logic [ByteW-1:0] v);
      logic [ByteW-1:0] junk;
      junk = ByteW'($urandom_range(255));
      return {junk, v};
   endfunction

   task automatic configure(logic [ByteW-1:0] flag, logic [ByteW-1:0] cmd_addr,
                            logic [ByteW-1:0] ans_addr, logic [ByteW-1:0] set_c,
                            logic [ByteW-1:0] ua_c, logic [ByteW-1:0] disc_c,
                            logic [AttemptW-1:0] max_att, logic [TickW-1:0] timeout);
      logic [11:0] junk;
      junk = 12'($urandom_range(4095));
      wait_idle();
      csr_write(REG_FLAG,      with_junk(flag));
      csr_write(REG_CMD_ADDR,  with_junk(cmd_addr));
      csr_write(REG_ANS_ADDR,  with_junk(ans_addr));
      csr_write(REG_SET_CTRL,  with_junk(set_c));
      csr_write(REG_UA_CTRL,   with_junk(ua_c));
      csr_write(REG_DISC_CTRL, with_junk(disc_c));
      csr_write(REG_MAX_ATT,   {junk, max_att});
      csr_write(REG_TIMEOUT,   timeout);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure_random();
      configure(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                AttemptW'($urandom_range(15, 1)), TickW'($urandom_range(6, 1)));
   endtask

   // reply frame from the peer, with optional ticks and damaged bytes
   task automatic send_reply(logic [ByteW-1:0] addr, logic [ByteW-1:0] ctrl);
      logic [ByteW-1:0] bytes [FrameLen];
      logic [ByteW-1:0] b;
      int               k;
      bytes[0] = cfg_flag;
      bytes[1] = addr;
      bytes[2] = ctrl;
      bytes[3] = addr ^ ctrl;
      bytes[4] = cfg_flag;
      for (k = 0; k < FrameLen; k++) begin
         if ($urandom_range(99) < 15)
            repeat ($urandom_range(2, 1)) send_word(CMD_TICK, ByteW'($urandom));
         b = bytes[k];
         if ($urandom_range(99) < 8)
            b = $urandom_range(1) ? cfg_flag : ByteW'($urandom_range(255));
         send_word(CMD_BYTE, b);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_idle_and_unused_cmds();
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_BYTE, cfg_flag);
      send_word(CmdUnused, 8'hFF);
   endtask

   // noise before the frame, stray flag resync, then clean DISC reply
   task automatic test_full_handshake();
      send_word(CMD_START, 8'h5A);
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, cfg_flag);
      send_word(CMD_BYTE, cfg_cmd_addr);
      send_word(CMD_BYTE, cfg_flag);
      send_word(CMD_BYTE, cfg_cmd_addr);
      send_word(CMD_BYTE, cfg_ua_ctrl);
      send_word(CMD_BYTE, cfg_cmd_addr ^ cfg_ua_ctrl);
      send_word(CMD_BYTE, cfg_flag);
      send_word(CMD_BYTE, cfg_flag);
      send_word(CMD_BYTE, cfg_ans_addr);
      send_word(CMD_BYTE, cfg_disc_ctrl);
      send_word(CMD_BYTE, cfg_ans_addr ^ cfg_disc_ctrl);
      send_word(CMD_BYTE, cfg_flag);
   endtask

   task automatic test_retry_then_give_up();
      send_word(CMD_START, 8'hA5);
      repeat (int'(cfg_timeout) * int'(cfg_max_att)) send_word(CMD_TICK, 8'hFF);
      send_word(CMD_BYTE, cfg_flag);
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned target;
      int unsigned sel;
      int unsigned run_out;
      target = items_sent + count;
      while (items_sent < target) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            send_word(CMD_START, ByteW'($urandom));
            send_reply(cfg_cmd_addr, cfg_ua_ctrl);
            send_reply(cfg_ans_addr, cfg_disc_ctrl);
         end else if (sel < 80) begin
            send_word(CMD_START, ByteW'($urandom));
            if ($urandom_range(1)) send_reply(cfg_cmd_addr, cfg_ua_ctrl);
            run_out = int'(cfg_timeout) * int'(cfg_max_att) + 1;
            if (run_out <= 64) repeat (run_out) send_word(CMD_TICK, ByteW'($urandom));
            else repeat ($urandom_range(8, 1)) send_word(CMD_TICK, ByteW'($urandom));
         end else begin
            repeat ($urandom_range(4, 1))
               send_word(CmdW'($urandom_range(3)), ByteW'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset_link_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_and_unused_cmds();
      test_full_handshake();
      test_retry_then_give_up();

      configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1, 16'd1);
      test_random_traffic(50);

      configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd15, 16'hFFFF);
      src_idle_pct = 47;
      test_random_traffic(50);

      configure_random();
      src_idle_pct   = 0;
      sink_stall_pct = 47;
      test_random_traffic(70);

      configure_random();
      src_idle_pct   = 19;
      sink_stall_pct = 19;
      test_random_traffic(70);

      configure(8'h7E, 8'h03, 8'h01, 8'h03, 8'h07, 8'h0B, 4'd15, 16'd2);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      test_random_traffic(70);

      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && words_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule : tb_top

FILE: sim.f
sv/lstc_pkg.sv
sv/lstc_front.sv
sv/lstc_queue.sv
sv/lstc_back.sv
sv/link_setup_teardown_controller.sv
bench/tb_top.sv
